// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/rksf_pkg.sv =====
// ----------------------------------------------------------------------------
// rksf_pkg
// Types and constants shared by the record key select filter files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rksf_pkg;

	localparam int DATA_W       = 8;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_IDX_W    = 3;
	localparam int REC_LEN_W    = 7;
	localparam int FLD_START_W  = 6;
	localparam int FLD_LEN_W    = 4;
	localparam int KEY_W        = 64;
	localparam int KEY_LEN_W    = 4;

	localparam logic [DATA_W-1:0] NEWLINE_BYTE = 8'h0A;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RECORD_LENGTH = 3'd0,
		CFG_FIELD_START   = 3'd1,
		CFG_FIELD_LENGTH  = 3'd2,
		CFG_MATCH_MODE    = 3'd3,
		CFG_KEY_BYTES     = 3'd4,
		CFG_KEY_LENGTH    = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_ALL = 2'd0,
		MODE_EQ  = 2'd1,
		MODE_GE  = 2'd2,
		MODE_LE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CMP_EQUAL   = 2'd0,
		CMP_LESS    = 2'd1,
		CMP_GREATER = 2'd2
	} cmp_t;

	typedef enum logic {
		ST_COLLECT = 1'b0,
		ST_REPLAY  = 1'b1
	} state_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              last;
	} beat_t;

endpackage

// ===== design/rksf_if.sv =====
// ----------------------------------------------------------------------------
// rksf_if
// Valid/ready channel interfaces for the input bytes and the selected bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rksf_in_if;
	logic                        valid;
	logic                        ready;
	logic [rksf_pkg::DATA_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface rksf_out_if;
	logic                        valid;
	logic                        ready;
	logic [rksf_pkg::DATA_W-1:0] out_byte;
	logic                        record_end;

	modport source (output valid, output out_byte, output record_end, input ready);
	modport sink (input valid, input out_byte, input record_end, output ready);
endinterface

// ===== design/rksf_out_fifo.sv =====
// ----------------------------------------------------------------------------
// rksf_out_fifo
// Two-entry output queue that decouples the replay reads from the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rksf_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rksf_pkg::beat_t     push_beat,
	input  logic                pop,
	output rksf_pkg::beat_t     head,
	output logic [1:0]          count
);
	import rksf_pkg::*;

	beat_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign head  = ent_q[rd_ptr_q];
	assign count = cnt_q;

endmodule

// ===== design/record_key_select_filter.sv =====
// ----------------------------------------------------------------------------
// record_key_select_filter
// Cuts a byte stream into fixed-length records and passes those whose key
// field compares against the configured key as the match mode selects.
// ----------------------------------------------------------------------------
// The in_ch channel takes one raw byte per transaction; newline bytes are
// accepted and dropped. Each other byte is written into the record memory
// and folded into the running key comparison in the same cycle.
// When the last byte of a record arrives and the record passes, the block
// replays the record from memory, one read per cycle while an output queue
// slot is free, onto out_ch, with record_end set on the final byte. The first
// byte of a selected record goes through the state register, the memory read
// register and the output queue before it is shown. While a record is
// replayed, in_ch is held not ready. The replay rate is set by the single
// read port of the record memory.
// A two-entry output queue absorbs receiver stalls: reads are issued only
// while a queue slot is free, so nothing is lost when out_ch is held off.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data.
// Reset clears the configuration to its defaults, the record position and
// the comparison state; the record memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module record_key_select_filter #(
	parameter int MAX_RECORD_BYTES = 64,
	parameter int MAX_KEY_BYTES    = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	rksf_in_if.sink                            in_ch,
	rksf_out_if.source                         out_ch,
	input  logic                               cfg_wr_en,
	input  logic [rksf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rksf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rksf_pkg::*;

	localparam int POS_W  = $clog2(MAX_RECORD_BYTES + 1);
	localparam int ADDR_W = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
	localparam int KCNT_W = $clog2(MAX_KEY_BYTES + 1);
	localparam logic [REC_LEN_W-1:0] MAX_LEN = REC_LEN_W'(MAX_RECORD_BYTES);
	localparam logic [KEY_LEN_W-1:0] MAX_KEY = KEY_LEN_W'(MAX_KEY_BYTES);

	logic [REC_LEN_W-1:0]   rec_len_q;
	logic [FLD_START_W-1:0] fld_start_q;
	logic [FLD_LEN_W-1:0]   fld_len_q;
	mode_t                  mode_q;
	logic [KEY_W-1:0]       key_q;
	logic [KEY_LEN_W-1:0]   key_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_len_q   <= REC_LEN_W'(64);
			fld_start_q <= '0;
			fld_len_q   <= FLD_LEN_W'(1);
			mode_q      <= MODE_ALL;
			key_q       <= '0;
			key_len_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_RECORD_LENGTH: rec_len_q   <= cfg_data[REC_LEN_W-1:0];
				CFG_FIELD_START:   fld_start_q <= cfg_data[FLD_START_W-1:0];
				CFG_FIELD_LENGTH:  fld_len_q   <= cfg_data[FLD_LEN_W-1:0];
				CFG_MATCH_MODE:    mode_q      <= mode_t'(cfg_data[1:0]);
				CFG_KEY_BYTES:     key_q       <= cfg_data[KEY_W-1:0];
				CFG_KEY_LENGTH:    key_len_q   <= cfg_data[KEY_LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	state_t            state_q;
	state_t            state_nx;
	logic [POS_W-1:0]  pos_q;
	cmp_t              cmp_q;
	logic [KCNT_W-1:0] seen_q;
	logic [POS_W-1:0]  rp_len_q;
	logic [POS_W-1:0]  rd_cnt_q;

	logic [REC_LEN_W-1:0] len_eff;
	logic [KEY_LEN_W-1:0] flen_eff;
	logic [KEY_LEN_W-1:0] klen_eff;
	logic [7:0]           pos8;
	logic [7:0]           fs8;
	logic [7:0]           fend8;
	logic [KEY_LEN_W-1:0] seen4;
	logic [KEY_LEN_W-1:0] seen_nx4;
	logic [2:0]           key_sel;
	logic [DATA_W-1:0]    key_byte;
	logic                 in_field;
	cmp_t                 cmp_nx;
	cmp_t                 cmp_fin;
	logic [KCNT_W-1:0]    seen_nx;
	logic [POS_W-1:0]     pos_nx;
	logic                 rec_end;
	logic                 pass;
	logic                 in_accept;
	logic                 byte_take;
	logic                 start_replay;
	logic                 in_ready_c;
	logic                 rd_active;
	logic                 rd_en;
	logic                 rd_last;
	logic                 issue_ok;
	logic [2:0]           occ_after;

	assign len_eff  = (rec_len_q == '0) ? REC_LEN_W'(1) :
		((rec_len_q > MAX_LEN) ? MAX_LEN : rec_len_q);
	assign flen_eff = (fld_len_q > MAX_KEY) ? MAX_KEY : fld_len_q;
	assign klen_eff = (key_len_q > MAX_KEY) ? MAX_KEY : key_len_q;
	assign pos8     = 8'(pos_q);
	assign fs8      = 8'(fld_start_q);
	assign fend8    = fs8 + 8'(flen_eff);
	assign seen4    = KEY_LEN_W'(seen_q);
	assign key_sel  = 3'(seen_q);
	assign key_byte = key_q[{key_sel, 3'b000} +: DATA_W];
	assign in_field = (pos8 >= fs8) && (pos8 < fend8) && (seen4 < MAX_KEY);

	always_comb begin
		cmp_nx = cmp_q;
		if (in_field && (cmp_q == CMP_EQUAL)) begin
			if (seen4 < klen_eff) begin
				if (in_ch.data_byte < key_byte) begin
					cmp_nx = CMP_LESS;
				end else if (in_ch.data_byte > key_byte) begin
					cmp_nx = CMP_GREATER;
				end
			end else begin
				cmp_nx = CMP_GREATER;
			end
		end
	end

	assign seen_nx  = seen_q + KCNT_W'(in_field);
	assign seen_nx4 = KEY_LEN_W'(seen_nx);
	assign pos_nx   = pos_q + POS_W'(1);
	assign rec_end  = REC_LEN_W'(pos_nx) >= len_eff;
	assign cmp_fin  = ((cmp_nx == CMP_EQUAL) && (seen_nx4 < klen_eff)) ? CMP_LESS : cmp_nx;

	always_comb begin
		unique case (mode_q)
			MODE_ALL: pass = 1'b1;
			MODE_EQ:  pass = (cmp_fin == CMP_EQUAL);
			MODE_GE:  pass = (cmp_fin != CMP_LESS);
			MODE_LE:  pass = (cmp_fin != CMP_GREATER);
			default:  pass = 1'b0;
		endcase
	end

	assign in_accept    = in_ch.valid && in_ready_c;
	assign byte_take    = in_accept && (in_ch.data_byte != NEWLINE_BYTE);
	assign start_replay = byte_take && rec_end && pass;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cmp_q  <= CMP_EQUAL;
			seen_q <= '0;
		end else if (byte_take) begin
			if (rec_end) begin
				pos_q  <= '0;
				cmp_q  <= CMP_EQUAL;
				seen_q <= '0;
			end else begin
				pos_q  <= pos_nx;
				cmp_q  <= cmp_nx;
				seen_q <= seen_nx;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_COLLECT: begin
				if (start_replay) begin
					state_nx = ST_REPLAY;
				end
			end
			ST_REPLAY: begin
				if (rd_en && rd_last) begin
					state_nx = ST_COLLECT;
				end
			end
			default: state_nx = ST_COLLECT;
		endcase
	end

	always_comb begin
		in_ready_c = 1'b0;
		rd_active  = 1'b0;
		unique case (state_q)
			ST_COLLECT: in_ready_c = 1'b1;
			ST_REPLAY:  rd_active  = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_COLLECT;
			rp_len_q <= '0;
			rd_cnt_q <= '0;
		end else begin
			state_q <= state_nx;
			if (start_replay) begin
				rp_len_q <= pos_nx;
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + POS_W'(1);
			end
		end
	end

	// Record memory: one write port for incoming bytes, one registered read port
	// for the replay. Writes and replay reads never overlap in time.
	logic [DATA_W-1:0] rec_mem [MAX_RECORD_BYTES];
	logic [DATA_W-1:0] rd_data_s1;
	logic              rd_last_s1;
	logic              rd_valid_s1;

	always_ff @(posedge clk) begin
		if (byte_take) begin
			rec_mem[pos_q[ADDR_W-1:0]] <= in_ch.data_byte;
		end
		if (rd_en) begin
			rd_data_s1 <= rec_mem[rd_cnt_q[ADDR_W-1:0]];
			rd_last_s1 <= rd_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
		end
	end

	beat_t      push_beat;
	beat_t      head;
	logic [1:0] fifo_count;
	logic       pop;

	assign push_beat = '{data: rd_data_s1, last: rd_last_s1};
	assign pop       = out_ch.valid && out_ch.ready;
	assign occ_after = 3'(fifo_count) + 3'(rd_valid_s1) - 3'(pop);
	assign issue_ok  = occ_after <= 3'd1;
	assign rd_en     = rd_active && issue_ok;
	assign rd_last   = (rd_cnt_q + POS_W'(1)) == rp_len_q;

	rksf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rd_valid_s1),
		.push_beat (push_beat),
		.pop       (pop),
		.head      (head),
		.count     (fifo_count)
	);

	assign in_ch.ready       = in_ready_c;
	assign out_ch.valid      = fifo_count != 2'd0;
	assign out_ch.out_byte   = head.data;
	assign out_ch.record_end = head.last;

endmodule

// ===== design/rksf_checker.sv =====
// ----------------------------------------------------------------------------
// rksf_checker
// Port-level checks for the record key select filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rksf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_record_end
);

	// A stalled output transaction stays offered with the same payload.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_byte) && $stable(out_record_end))

	// The input side closes only right after a byte completes a record.
	`ASSERT_IMPLY(a_ready_fall, clk, arst_n, $fell(in_ready), $past(in_valid && in_ready))

	// Once the replay reads are done, the last byte is waiting at the output.
	`ASSERT_NEXT(a_replay_tail, clk, arst_n, $rose(in_ready), out_valid)

endmodule

bind record_key_select_filter rksf_checker u_rksf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.out_byte       (out_ch.out_byte),
	.out_record_end (out_ch.record_end)
);
